// File: hdl/ttle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttle_pkg
// types, codes and reset values shared by the cursor and line editor blocks
// ----------------------------------------------------------------------------
package ttle_pkg;

  // field widths
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CELL_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // default parameter values
  localparam int unsigned LINE_CHARS_DEF  = 128;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register reset values
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 10'd240;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 10'd240;
  localparam logic [COORD_W-1:0] TOP_ROW_RST       = 10'd20;
  localparam logic [CELL_W-1:0]  CELL_HEIGHT_RST   = 6'd7;
  localparam logic [CELL_W-1:0]  CELL_WIDTH_RST    = 6'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ROW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd4;

  // input kinds
  localparam logic [1:0] KIND_DISPLAY = 2'd0;
  localparam logic [1:0] KIND_KEY     = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  // result actions
  localparam logic [2:0] ACT_SERIAL = 3'd0;
  localparam logic [2:0] ACT_DRAW   = 3'd1;
  localparam logic [2:0] ACT_ERASE  = 3'd2;
  localparam logic [2:0] ACT_STORE  = 3'd3;
  localparam logic [2:0] ACT_EXEC   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  // character codes
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_DEL   = 8'h7F;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_req;
  } in_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         out_byte;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COUNT_W-1:0] count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
    logic [COORD_W-1:0] top_row;
    logic [CELL_W-1:0]  cell_height;
    logic [CELL_W-1:0]  cell_width;
  } cfg_t;

  // classified command between front and back
  typedef enum logic [2:0] {
    OP_DISP,
    OP_CHAR,
    OP_BS,
    OP_ENTER,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         chr;
    logic [COUNT_W-1:0] cnt;
  } cmd_t;

endpackage

// File: hdl/ttle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttle_front
// accepts input items, tracks the edit line length and issues commands
// ----------------------------------------------------------------------------
module ttle_front #(
  parameter int LINE_CHARS = ttle_pkg::LINE_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  ttle_pkg::in_t  in_i,
  output logic           in_stall_o,
  input  logic           q_full_i,
  output logic           push_o,
  output ttle_pkg::cmd_t cmd_o
);
  import ttle_pkg::*;

  localparam int LenW = $clog2(LINE_CHARS);

  logic [LenW-1:0] len_q, len_d;
  logic            accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    len_d      = len_q;
    push_o     = 1'b0;
    cmd_o.op   = OP_DISP;
    cmd_o.chr  = in_i.byte_req;
    cmd_o.cnt  = '0;
    if (accept) begin
      case (in_i.kind)
        KIND_DISPLAY: begin
          push_o = 1'b1;
        end
        KIND_CLEAR: begin
          push_o   = 1'b1;
          cmd_o.op = OP_CLEAR;
        end
        KIND_KEY: begin
          if (in_i.byte_req inside {CHR_CR, CHR_LF}) begin
            // enter only acts on a non-empty line
            if (len_q != '0) begin
              push_o    = 1'b1;
              cmd_o.op  = OP_ENTER;
              cmd_o.chr = CHR_LF;
              cmd_o.cnt = COUNT_W'(len_q);
              len_d     = '0;
            end
          end else if (in_i.byte_req inside {CHR_BS, CHR_DEL}) begin
            if (len_q != '0) begin
              push_o    = 1'b1;
              cmd_o.op  = OP_BS;
              cmd_o.chr = CHR_BS;
              len_d     = len_q - 1'b1;
            end
          end else if (len_q < LenW'(LINE_CHARS - 1)) begin
            push_o    = 1'b1;
            cmd_o.op  = OP_CHAR;
            cmd_o.cnt = COUNT_W'(len_q);
            len_d     = len_q + 1'b1;
          end
        end
        default: begin
          // unused kind: accepted and dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

// File: hdl/ttle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttle_fifo
// small command queue between the front and the back
// ----------------------------------------------------------------------------
module ttle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ttle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttle_back
// steps through the results of each command and keeps the pixel cursor
// ----------------------------------------------------------------------------
module ttle_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ttle_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  ttle_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ttle_pkg::out_t out_o
);
  import ttle_pkg::*;

  logic [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [1:0]         step_q, step_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               load;
  logic               fin;
  out_t               res;
  out_t               rnd_res;
  logic               rnd_emit;
  logic               bs_ok;
  logic [COORD_W:0]   nl_sum, adv_sum;
  logic               nl_wrap, adv_wrap;
  logic [COORD_W-1:0] nl_y, nx, ny;

  assign load = !out_valid_q || !out_stall_i;

  // cursor arithmetic at full precision
  always_comb begin
    bs_ok    = (cx_q >= {4'b0, cfg_i.cell_width});
    nl_sum   = {1'b0, cy_q} + (COORD_W+1)'(cfg_i.cell_height);
    nl_wrap  = (nl_sum + (COORD_W+1)'(cfg_i.cell_height)) >
               {1'b0, cfg_i.screen_height};
    nl_y     = nl_wrap ? cfg_i.top_row : nl_sum[COORD_W-1:0];
    adv_sum  = {1'b0, cx_q} + (COORD_W+1)'(cfg_i.cell_width);
    adv_wrap = (adv_sum + (COORD_W+1)'(cfg_i.cell_width)) >
               {1'b0, cfg_i.screen_width};
  end

  // render of the command byte: result and next cursor
  always_comb begin
    rnd_res  = '0;
    rnd_emit = 1'b0;
    nx       = cx_q;
    ny       = cy_q;
    if (cmd_i.chr == CHR_BS) begin
      rnd_emit       = bs_ok;
      rnd_res.action = ACT_ERASE;
      rnd_res.pos_x  = cx_q - {4'b0, cfg_i.cell_width};
      rnd_res.pos_y  = cy_q;
    end else begin
      rnd_emit         = (cmd_i.chr >= CHR_SPACE);
      rnd_res.action   = ACT_DRAW;
      rnd_res.out_byte = cmd_i.chr;
      rnd_res.pos_x    = cx_q;
      rnd_res.pos_y    = cy_q;
    end
    if (cmd_i.op == OP_CLEAR) begin
      nx = '0;
      ny = cfg_i.top_row;
    end else if (cmd_i.chr == CHR_CR) begin
      nx = '0;
    end else if (cmd_i.chr == CHR_LF) begin
      nx = '0;
      ny = nl_y;
    end else if (cmd_i.chr == CHR_BS) begin
      if (bs_ok) begin
        nx = cx_q - {4'b0, cfg_i.cell_width};
      end
    end else if (cmd_i.chr >= CHR_SPACE) begin
      if (adv_wrap) begin
        nx = '0;
        ny = nl_y;
      end else begin
        nx = adv_sum[COORD_W-1:0];
      end
    end
  end

  // result of the current step
  always_comb begin
    res = '0;
    fin = 1'b1;
    case (cmd_i.op)
      OP_DISP: begin
        case (step_q)
          2'd0: begin
            res.action   = ACT_SERIAL;
            res.out_byte = cmd_i.chr;
            fin          = !rnd_emit;
          end
          default: res = rnd_res;
        endcase
      end
      OP_CHAR: begin
        case (step_q)
          2'd0: begin
            res.action   = ACT_STORE;
            res.out_byte = cmd_i.chr;
            res.count    = cmd_i.cnt;
            fin          = 1'b0;
          end
          2'd1: begin
            res.action   = ACT_SERIAL;
            res.out_byte = cmd_i.chr;
            fin          = !rnd_emit;
          end
          default: res = rnd_res;
        endcase
      end
      OP_BS: begin
        case (step_q)
          2'd0: begin
            res.action   = ACT_SERIAL;
            res.out_byte = CHR_BS;
            fin          = 1'b0;
          end
          2'd1: begin
            res.action   = ACT_SERIAL;
            res.out_byte = CHR_SPACE;
            fin          = 1'b0;
          end
          2'd2: begin
            res.action   = ACT_SERIAL;
            res.out_byte = CHR_BS;
            fin          = !rnd_emit;
          end
          default: res = rnd_res;
        endcase
      end
      OP_ENTER: begin
        case (step_q)
          2'd0: begin
            res.action   = ACT_SERIAL;
            res.out_byte = CHR_CR;
            fin          = 1'b0;
          end
          2'd1: begin
            res.action   = ACT_SERIAL;
            res.out_byte = CHR_LF;
            fin          = 1'b0;
          end
          default: begin
            res.action = ACT_EXEC;
            res.count  = cmd_i.cnt;
          end
        endcase
      end
      OP_CLEAR: begin
        res.action = ACT_CLEAR;
        res.pos_y  = cfg_i.top_row;
      end
      default: begin
        res = '0;
      end
    endcase
    res.last = fin;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    step_d      = step_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cmd_pop_o   = 1'b0;
    if (load) begin
      out_valid_d = cmd_valid_i;
      if (cmd_valid_i) begin
        out_d = res;
        if (fin) begin
          step_d    = '0;
          cmd_pop_o = 1'b1;
          cx_d      = nx;
          cy_d      = ny;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cx_q        <= '0;
      cy_q        <= TOP_ROW_RST;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i && load)
    else $error("command popped without a loaded result");

  a_exec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.action == ACT_EXEC || out_q.action == ACT_CLEAR)
      |-> out_q.last)
    else $error("execute or clear result not marked last");

  a_serial_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action == ACT_SERIAL
      |-> out_q.pos_x == '0 && out_q.pos_y == '0 && out_q.count == '0)
    else $error("serial result carries position or count");

  a_step_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> step_q == '0)
    else $error("step counter not cleared after a command finished");

endmodule

// File: hdl/text_terminal_cursor_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_line_editor
// pixel cursor and keyboard line editor for a character-cell text terminal
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries display bytes, received
//   keyboard bytes and clear requests; each transaction yields zero to four
//   result transactions on the output channel (out_valid_o / out_stall_i),
//   the final one of each item flagged by last
//   configuration writes use cfg_valid_i / cfg_ready_o with a register index;
//   ready is always high; writes must be made only while the block is idle,
//   which the block itself does not enforce
// flow and throughput:
//   with the back end free, an item passes through the command queue and
//   then the output register before its first result appears
//   the back end sends one result per cycle unless the output stalls, and
//   an item yields one to four results there; an item with no results is
//   handled in the front alone and never enters the command queue
//   a short command queue lets new items be taken while results drain
// reset:
//   cursor goes to column 0 on row 20, the edit line is empty and the
//   registers take their reset values
// stalls:
//   a stalled output holds its result; the queue fills and in_stall_o rises
// ----------------------------------------------------------------------------
module text_terminal_cursor_line_editor #(
  parameter int LINE_CHARS  = ttle_pkg::LINE_CHARS_DEF,
  parameter int QUEUE_DEPTH = ttle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ttle_pkg::in_t                       in_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ttle_pkg::out_t                      out_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ttle_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ttle_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ttle_pkg::*;

  localparam int CmdW = $bits(cmd_t);

  cfg_t            cfg_q;
  logic            q_push, q_full, q_empty, q_pop;
  cmd_t            push_cmd, head_cmd;
  logic [CmdW-1:0] head_raw;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
      cfg_q.top_row       <= TOP_ROW_RST;
      cfg_q.cell_height   <= CELL_HEIGHT_RST;
      cfg_q.cell_width    <= CELL_WIDTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        REG_TOP_ROW:       cfg_q.top_row       <= cfg_data_i;
        REG_CELL_HEIGHT:   cfg_q.cell_height   <= cfg_data_i[CELL_W-1:0];
        REG_CELL_WIDTH:    cfg_q.cell_width    <= cfg_data_i[CELL_W-1:0];
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  // front: classify items and track the edit line length
  ttle_front #(
    .LINE_CHARS(LINE_CHARS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_i      (in_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .cmd_o     (push_cmd)
  );

  // command queue between front and back
  ttle_fifo #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_push),
    .wr_data_i(push_cmd),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .rd_data_o(head_raw),
    .empty_o  (q_empty)
  );

  assign head_cmd = cmd_t'(head_raw);

  // back: result sequencing, cursor and output register
  ttle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(!q_empty),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> in_stall_o)
    else $error("input not stalled with a full queue");

endmodule

// File: tb/text_terminal_cursor_line_editor_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_line_editor_check
// watches the item, result and configuration channels, keeps a copy of the
// cursor, edit line and registers, predicts the results of every accepted
// item and compares each accepted result field by field against the oldest
// pending prediction
// ----------------------------------------------------------------------------
module text_terminal_cursor_line_editor_check #(
  parameter int LINE_CHARS = ttle_pkg::LINE_CHARS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  ttle_pkg::in_t                   in_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  ttle_pkg::out_t                  out_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [ttle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ttle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  import ttle_pkg::*;

  // register copy
  logic [COORD_W-1:0] scr_w, scr_h, top_row;
  logic [CELL_W-1:0]  cell_h, cell_w;

  // cursor and edit line
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [COUNT_W-1:0] line_len;

  // results of the item being predicted, then the queue of pending results
  out_t        item_results [4];
  int unsigned n_item_results;
  out_t        pending_results [$];
  int unsigned error_count = 0;

  assign errors_o = error_count;

  function automatic void add_result(input logic [2:0] act, input logic [7:0] chr,
                                     input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [COUNT_W-1:0] cnt);
    out_t r;
    r.action   = act;
    r.out_byte = chr;
    r.pos_x    = x;
    r.pos_y    = y;
    r.count    = cnt;
    r.last     = 1'b0;
    item_results[n_item_results] = r;
    n_item_results++;
  endfunction

  function automatic void advance_line();
    int unsigned ny;
    ny    = cur_y + cell_h;
    cur_x = '0;
    if (ny + cell_h > scr_h) cur_y = top_row;
    else cur_y = COORD_W'(ny);
  endfunction

  function automatic void render_byte(input logic [7:0] chr);
    int unsigned nx;
    if (chr == CHR_CR) begin
      cur_x = '0;
    end else if (chr == CHR_LF) begin
      advance_line();
    end else if (chr == CHR_BS) begin
      if (cur_x >= cell_w) begin
        cur_x = cur_x - cell_w;
        add_result(ACT_ERASE, 8'h00, cur_x, cur_y, '0);
      end
    end else if (chr >= CHR_SPACE) begin
      add_result(ACT_DRAW, chr, cur_x, cur_y, '0);
      nx = cur_x + cell_w;
      if (nx + cell_w > scr_w) advance_line();
      else cur_x = COORD_W'(nx);
    end
  endfunction

  function automatic void compute_editor_results(input in_t item);
    logic [7:0] chr;
    chr = item.byte_req;
    n_item_results = 0;
    case (item.kind)
      KIND_DISPLAY: begin
        add_result(ACT_SERIAL, chr, '0, '0, '0);
        render_byte(chr);
      end
      KIND_CLEAR: begin
        add_result(ACT_CLEAR, 8'h00, '0, top_row, '0);
        cur_x = '0;
        cur_y = top_row;
      end
      KIND_KEY: begin
        if (chr == CHR_CR || chr == CHR_LF) begin
          if (line_len != 0) begin
            add_result(ACT_SERIAL, CHR_CR, '0, '0, '0);
            add_result(ACT_SERIAL, CHR_LF, '0, '0, '0);
            render_byte(CHR_CR);
            render_byte(CHR_LF);
            add_result(ACT_EXEC, 8'h00, '0, '0, line_len);
            line_len = '0;
          end
        end else if (chr == CHR_BS || chr == CHR_DEL) begin
          if (line_len != 0) begin
            line_len = line_len - 1'b1;
            add_result(ACT_SERIAL, CHR_BS, '0, '0, '0);
            add_result(ACT_SERIAL, CHR_SPACE, '0, '0, '0);
            add_result(ACT_SERIAL, CHR_BS, '0, '0, '0);
            render_byte(CHR_BS);
          end
        end else if (line_len < LINE_CHARS - 1) begin
          add_result(ACT_STORE, chr, '0, '0, line_len);
          line_len = line_len + 1'b1;
          add_result(ACT_SERIAL, chr, '0, '0, '0);
          render_byte(chr);
        end
      end
      default: ;
    endcase
    if (n_item_results != 0) item_results[n_item_results-1].last = 1'b1;
    for (int i = 0; i < n_item_results; i++) pending_results.push_back(item_results[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      scr_w    = SCREEN_WIDTH_RST;
      scr_h    = SCREEN_HEIGHT_RST;
      top_row  = TOP_ROW_RST;
      cell_h   = CELL_HEIGHT_RST;
      cell_w   = CELL_WIDTH_RST;
      cur_x    = '0;
      cur_y    = TOP_ROW_RST;
      line_len = '0;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SCREEN_WIDTH:  scr_w   = cfg_data_i;
          REG_SCREEN_HEIGHT: scr_h   = cfg_data_i;
          REG_TOP_ROW:       top_row = cfg_data_i;
          REG_CELL_HEIGHT:   cell_h  = cfg_data_i[CELL_W-1:0];
          REG_CELL_WIDTH:    cell_w  = cfg_data_i[CELL_W-1:0];
          default: ;
        endcase
      end
      // results first: a result at this edge belongs to an earlier item
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: action %0d byte %0d", out_i.action, out_i.out_byte);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("action",   want.action,   out_i.action);
          check_field("out_byte", want.out_byte, out_i.out_byte);
          check_field("pos_x",    want.pos_x,    out_i.pos_x);
          check_field("pos_y",    want.pos_y,    out_i.pos_y);
          check_field("count",    want.count,    out_i.count);
          check_field("last",     want.last,     out_i.last);
        end
      end
      if (in_valid_i && !in_stall_i) compute_editor_results(in_i);
      pending_o <= pending_results.size();
    end
  end

endmodule

// File: tb/text_terminal_cursor_line_editor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_line_editor_tb
// drives display bytes, keyboard bytes and clear requests into the cursor and
// line editor under several register settings, with random gaps and stalls,
// a long output hold and a full drain; the checker module does the
// prediction and comparison, this top gives the verdict
// ----------------------------------------------------------------------------
module text_terminal_cursor_line_editor_tb;
  import ttle_pkg::*;

  // kind code the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // output hold used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 48;
  // cycles allowed after the last result for items that produce nothing
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // item channel
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;

  // result channel
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // register writes
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned pending;
  int unsigned fails;

  // idling switch shared by sender and receiver, long hold request
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  always #6 clk = ~clk;

  text_terminal_cursor_line_editor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  text_terminal_cursor_line_editor_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (fails)
  );

  // receiver: short random stall bursts, or a long hold when requested
  initial begin : stall_gen
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        // a burst of stall cycles starts, this one included
        burst_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item, maybe after a short gap, and return at its transaction
  task automatic send_item(input logic [1:0] kind, input logic [7:0] chr);
    in_t item;
    int unsigned gap;
    item.kind     = kind;
    item.byte_req = chr;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // block must be idle when this is called
  task automatic program_registers(input logic [CFG_DATA_W-1:0] width,
                                   input logic [CFG_DATA_W-1:0] height,
                                   input logic [CFG_DATA_W-1:0] top,
                                   input logic [CFG_DATA_W-1:0] c_height,
                                   input logic [CFG_DATA_W-1:0] c_width);
    cfg_write(REG_SCREEN_WIDTH, width);
    cfg_write(REG_SCREEN_HEIGHT, height);
    cfg_write(REG_TOP_ROW, top);
    cfg_write(REG_CELL_HEIGHT, c_height);
    cfg_write(REG_CELL_WIDTH, c_width);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] edit_control();
    case ($urandom_range(0, 3))
      0:       return CHR_CR;
      1:       return CHR_LF;
      2:       return CHR_BS;
      default: return CHR_DEL;
    endcase
  endfunction

  // mostly printable text and line edits, some control noise and clears
  task automatic send_random_items(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 20)      send_item(KIND_DISPLAY, 8'($urandom_range(32, 255)));
      else if (r < 30) send_item(KIND_DISPLAY, 8'($urandom_range(0, 255)));
      else if (r < 38) send_item(KIND_DISPLAY, edit_control());
      else if (r < 70) send_item(KIND_KEY, 8'($urandom_range(32, 126)));
      else if (r < 78) send_item(KIND_KEY, 8'($urandom_range(0, 255)));
      else if (r < 88) send_item(KIND_KEY, edit_control());
      else if (r < 94) send_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
      else             send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rendering with reset registers
    send_item(KIND_DISPLAY, "A");
    send_item(KIND_DISPLAY, CHR_BS);      // erases the cell just drawn
    send_item(KIND_DISPLAY, CHR_SPACE);
    send_item(KIND_DISPLAY, CHR_DEL);     // drawn like any other glyph
    send_item(KIND_DISPLAY, 8'hFF);
    send_item(KIND_DISPLAY, 8'h80);
    send_item(KIND_DISPLAY, 8'h00);       // control byte echoed, not drawn
    send_item(KIND_DISPLAY, 8'h1F);
    send_item(KIND_DISPLAY, CHR_CR);
    send_item(KIND_DISPLAY, CHR_BS);      // column zero, nothing erased
    send_item(KIND_DISPLAY, CHR_LF);
    send_item(KIND_UNUSED, 8'hFF);        // ignored kind
    // directed: edit line
    send_item(KIND_KEY, CHR_CR);          // enter on empty line
    send_item(KIND_KEY, CHR_BS);          // erase on empty line
    send_item(KIND_KEY, CHR_DEL);
    send_item(KIND_KEY, "h");
    send_item(KIND_KEY, "i");
    send_item(KIND_KEY, 8'h01);           // stored and echoed, not drawn
    send_item(KIND_KEY, CHR_DEL);
    send_item(KIND_KEY, CHR_BS);
    send_item(KIND_KEY, 8'hFF);
    send_item(KIND_KEY, CHR_LF);          // execute, length two
    send_item(KIND_KEY, "q");
    send_item(KIND_KEY, CHR_CR);
    send_item(KIND_CLEAR, 8'hFF);
    wait_drained();

    // smallest screen and cells, with a long output hold mid-phase
    program_registers(10'd8, 10'd8, 10'd0, 10'd1, 10'd1);
    send_random_items(5);
    long_hold_req = 1'b1;
    send_random_items(20);
    wait_drained();

    // largest values, no idling
    idle_on = 1'b0;
    program_registers(10'd1023, 10'd1023, 10'd1023, 10'd63, 10'd63);
    send_random_items(20);
    wait_drained();

    // random registers, and a sender pause mid-phase
    idle_on = 1'b1;
    program_registers(CFG_DATA_W'($urandom_range(8, 1023)),
                      CFG_DATA_W'($urandom_range(8, 1023)),
                      CFG_DATA_W'($urandom_range(0, 1023)),
                      CFG_DATA_W'($urandom_range(1, 63)),
                      CFG_DATA_W'($urandom_range(1, 63)));
    send_random_items(10);
    send_item(KIND_KEY, CHR_CR);
    wait_drained();
    send_random_items(20);
    wait_drained();

    // back to reset values, final stretch without idling
    idle_on = 1'b0;
    program_registers(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, TOP_ROW_RST,
                      CFG_DATA_W'(CELL_HEIGHT_RST), CFG_DATA_W'(CELL_WIDTH_RST));
    send_random_items(25);
    wait_drained();

    if (fails == 0) begin
      $display("** text_terminal_cursor_line_editor: PASSED **");
    end else begin
      $display("** text_terminal_cursor_line_editor: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("** text_terminal_cursor_line_editor: FAILED **");
    $finish;
  end

endmodule
